FILE: sv/ssic_pkg.sv
// shared types and constants for the square spiral index codec
`default_nettype none

package ssic_pkg;

  // fixed field widths of the request and result
  localparam int INDEX_W = 9;
  localparam int COORD_W = 5;
  // ring counter width, enough for the largest supported ring count
  localparam int RING_W  = 4;
  // width of the signed scratch arithmetic for offsets
  localparam int CALC_W  = 12;

  // one request in flight along the cell chain
  typedef struct packed {
    logic               valid;
    logic               decode;
    logic               center;
    logic [INDEX_W-1:0] enc_index;
    logic [INDEX_W-1:0] k;
    logic [RING_W-1:0]  n;
  } ssic_item_t;

endpackage

`default_nettype wire

FILE: sv/ssic_cell.sv
// one ring cell: peels its ring off the remaining index and hands the request on
`default_nettype none

module ssic_cell import ssic_pkg::*; #(
  parameter int RING    = 1,
  parameter bit STEP_EN = 1'b1
) (
  input  logic       clk,
  input  logic       rst,
  input  ssic_item_t item_in,
  output ssic_item_t item_out
);

  // positions held by this ring
  localparam logic [INDEX_W-1:0] SPAN = INDEX_W'(8 * RING);

  ssic_item_t item_next;

  always_comb begin
    item_next = item_in;
    if (STEP_EN && (item_in.k >= SPAN)) begin
      item_next.k = item_in.k - SPAN;
      item_next.n = RING_W'(RING + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssic_place.sv
// output stage: ring and offset to a point, or the index; registers result
`default_nettype none

module ssic_place import ssic_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ssic_item_t                item_in,
  output logic                      done,
  output logic [INDEX_W-1:0]        result_index,
  output logic signed [COORD_W-1:0] result_x,
  output logic signed [COORD_W-1:0] result_y
);

  logic signed [CALC_W-1:0] kk;
  logic signed [CALC_W-1:0] nn;
  logic signed [CALC_W-1:0] px;
  logic signed [CALC_W-1:0] py;

  always_comb begin
    kk = signed'(CALC_W'(item_in.k));
    nn = signed'(CALC_W'(item_in.n));
    priority if (kk < 2 * nn + 1) begin
      px = nn;
      py = kk - nn;
    end else if (kk < 4 * nn + 1) begin
      px = CALC_W'(3 * nn - kk);
      py = nn;
    end else if (kk < 6 * nn + 1) begin
      px = -nn;
      py = CALC_W'(5 * nn - kk);
    end else begin
      px = CALC_W'(kk - 7 * nn);
      py = -nn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_in.valid;
    end
    if (item_in.decode) begin
      result_index <= '0;
      if (item_in.center) begin
        result_x <= '0;
        result_y <= '0;
      end else begin
        result_x <= px[COORD_W-1:0];
        result_y <= py[COORD_W-1:0];
      end
    end else begin
      result_index <= item_in.enc_index;
      result_x     <= '0;
      result_y     <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/square_spiral_index_codec.sv
// top level of the square spiral index codec: encode point to index, decode index to point
// a request passes through the MAX_RING ring cells and then the result register before the done strobe
// throughput: one request per cycle; the ring cells form a pipeline, so busy stays low
// the delay is set by the chain of MAX_RING registered ring cells and the result register
// result is on the result ports for one cycle with done high; the receiver cannot stall
// reset (rst, synchronous) empties the chain and clears done; results in flight are dropped
`default_nettype none

module square_spiral_index_codec import ssic_pkg::*; #(
  parameter int MAX_RING = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic [INDEX_W-1:0]        position,
  output logic                      done,
  output logic [INDEX_W-1:0]        result_index,
  output logic signed [COORD_W-1:0] result_x,
  output logic signed [COORD_W-1:0] result_y
);

  // largest index in the spiral
  localparam int TOP_INDEX = 4 * MAX_RING * (MAX_RING + 1);
  localparam logic signed [COORD_W-1:0] RING_MAX = COORD_W'(MAX_RING);
  localparam logic signed [COORD_W-1:0] RING_MIN = -RING_MAX;
  localparam int BASE_W = 11;

  // every stage advances each cycle, so a request can always be taken
  assign busy = 1'b0;

  // ---------------- decode front: saturate index, start at ring one
  logic [INDEX_W-1:0] idx_sat;

  always_comb begin
    if (int'(position) > TOP_INDEX) begin
      idx_sat = INDEX_W'(TOP_INDEX);
    end else begin
      idx_sat = position;
    end
  end

  // ---------------- encode: clamp, find ring, add edge offset to ring base
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [COORD_W-1:0] ax;
  logic signed [COORD_W-1:0] ay;
  logic [RING_W-1:0]         en;
  logic [BASE_W-1:0]         base;
  logic signed [CALC_W-1:0]  sx;
  logic signed [CALC_W-1:0]  sy;
  logic signed [CALC_W-1:0]  sn;
  logic signed [CALC_W-1:0]  off;
  logic signed [CALC_W-1:0]  enc_sum;

  always_comb begin
    // saturate each coordinate to the outermost ring
    priority if (point_x > RING_MAX) begin
      cx = RING_MAX;
    end else if (point_x < RING_MIN) begin
      cx = RING_MIN;
    end else begin
      cx = point_x;
    end
    priority if (point_y > RING_MAX) begin
      cy = RING_MAX;
    end else if (point_y < RING_MIN) begin
      cy = RING_MIN;
    end else begin
      cy = point_y;
    end

    // ring number is the larger magnitude
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    en = (ax > ay) ? ax[RING_W-1:0] : ay[RING_W-1:0];

    // first index of ring n is 1 + 4n(n-1)
    base = BASE_W'(1) + BASE_W'({en, 2'b00}) * BASE_W'(en - RING_W'(1));

    sx = CALC_W'(cx);
    sy = CALC_W'(cy);
    sn = signed'(CALC_W'(en));

    // right, top, left, then bottom edge
    priority if (sx == sn) begin
      off = sn + sy;
    end else if (sy == sn) begin
      off = CALC_W'(3 * sn - sx);
    end else if (sx == -sn) begin
      off = CALC_W'(5 * sn - sy);
    end else begin
      off = CALC_W'(7 * sn + sx);
    end

    enc_sum = signed'(CALC_W'(base)) + off;
  end

  // ---------------- ring cell chain
  ssic_item_t chain [0:MAX_RING];

  always_comb begin
    chain[0].valid     = start & ~busy;
    chain[0].decode    = action;
    chain[0].center    = (idx_sat == '0);
    chain[0].enc_index = (en == '0) ? '0 : enc_sum[INDEX_W-1:0];
    chain[0].k         = idx_sat - INDEX_W'(1);
    chain[0].n         = RING_W'(1);
  end

  // cell g strips ring g; the outermost ring never steps further
  for (genvar g = 1; g <= MAX_RING; g++) begin : g_cell
    ssic_cell #(
      .RING    (g),
      .STEP_EN (g < MAX_RING)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .item_in  (chain[g-1]),
      .item_out (chain[g])
    );
  end

  // ---------------- result register
  ssic_place u_place (
    .clk          (clk),
    .rst          (rst),
    .item_in      (chain[MAX_RING]),
    .done         (done),
    .result_index (result_index),
    .result_x     (result_x),
    .result_y     (result_y)
  );

endmodule

`default_nettype wire
